>>> hw/rtl/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Shared types and constants of the scanline span fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package psf_pkg;

  localparam int DEF_MAX_VERTICES    = 16;
  localparam int DEF_COORD_FRAC_BITS = 4;
  localparam int CROSS_FRAC_BITS     = 8;
  localparam int MAX_SPANS           = 8;
  localparam int MIN_POLY_VERTICES   = 3;

  localparam int COORD_W    = 16;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 12;
  localparam int FLAT_W     = 24;
  localparam int CFG_W      = 13;
  localparam int CFG_ADDR_W = 2;
  localparam int MAX_COLS   = 4096;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd512;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd512;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_CLEAR  = 2'd0;
  localparam opcode_t OP_APPEND = 2'd1;
  localparam opcode_t OP_QUERY  = 2'd2;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  localparam cfg_addr_t REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_addr_t REG_IMAGE_HEIGHT = 2'd1;

endpackage

`default_nettype wire

>>> hw/rtl/psf_if.sv
// ----------------------------------------------------------------------------
// psf_if
// Request, result and configuration channels of the span fill block.
// ----------------------------------------------------------------------------
`default_nettype none

interface psf_req_if;
  import psf_pkg::*;
  logic                       valid;
  logic                       ready;
  opcode_t                    opcode;
  logic signed [COORD_W-1:0]  vertex_x;
  logic signed [COORD_W-1:0]  vertex_y;
  logic        [ROW_W-1:0]    query_row;
  modport source (output valid, opcode, vertex_x, vertex_y, query_row, input ready);
  modport sink   (input valid, opcode, vertex_x, vertex_y, query_row, output ready);
endinterface

interface psf_rsp_if;
  import psf_pkg::*;
  logic              valid;
  logic              ready;
  logic              span_valid;
  logic [COL_W-1:0]  span_start;
  logic [COL_W-1:0]  span_end;
  logic [FLAT_W-1:0] start_index;
  logic              last_span;
  modport source (output valid, span_valid, span_start, span_end, start_index, last_span,
                  input ready);
  modport sink   (input valid, span_valid, span_start, span_end, start_index, last_span,
                  output ready);
endinterface

interface psf_cfg_if;
  import psf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/psf_vstore.sv
// ----------------------------------------------------------------------------
// psf_vstore
// Vertex memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_vstore #(
  parameter int DEPTH = psf_pkg::DEF_MAX_VERTICES,
  parameter int AW    = $clog2(psf_pkg::DEF_MAX_VERTICES)
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [psf_pkg::COORD_W-1:0] wr_x,
  input  logic signed [psf_pkg::COORD_W-1:0] wr_y,
  input  logic [AW-1:0]                     rd_addr,
  output logic signed [psf_pkg::COORD_W-1:0] rd_x,
  output logic signed [psf_pkg::COORD_W-1:0] rd_y
);
  import psf_pkg::*;

  logic signed [COORD_W-1:0] mem_x [DEPTH];
  logic signed [COORD_W-1:0] mem_y [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/psf_div.sv
// ----------------------------------------------------------------------------
// psf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_div #(
  parameter int NW = 40,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic          rem_nz
);
  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem;
  logic [DW-1:0]   dsr;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     trial;
  logic [DW:0]     diff;

  assign trial  = {rem, quo[NW-1]};
  assign diff   = trial - {1'b0, dsr};
  assign rem_nz = |rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
      quo  <= num;
      dsr  <= den;
    end else if (busy) begin
      // shift in the next numerator bit, subtract when it fits
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == CNTW'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/polygon_scanline_span_fill_top.sv
// ----------------------------------------------------------------------------
// polygon_scanline_span_fill_top
// Even-odd scanline polygon fill, one span list per row request.
// ----------------------------------------------------------------------------
// Clear and append requests are handled without leaving idle. A row query
// walks every edge through one shared multiplier and a bit-serial divider,
// NUMW bits wide and 40 at the default coordinate format, then runs a bubble
// sort on the crossing register line, then pairs the sorted crossings into
// spans and hands each span over the result handshake. Requests are refused
// while a query is at work.
`default_nettype none

module polygon_scanline_span_fill_top #(
  parameter int MAX_VERTICES    = psf_pkg::DEF_MAX_VERTICES,
  parameter int COORD_FRAC_BITS = psf_pkg::DEF_COORD_FRAC_BITS
) (
  input logic        clk,
  input logic        rst,
  psf_req_if.sink    req,
  psf_rsp_if.source  rsp,
  psf_cfg_if.sink    cfg
);
  import psf_pkg::*;

  localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int YQW  = ROW_W + COORD_FRAC_BITS + 1;
  localparam int DYW  = ((YQW > COORD_W) ? YQW : COORD_W) + 1;
  localparam int DXW  = COORD_W + 1;
  localparam int PW   = DYW + DXW;
  localparam int SUMW = PW + 1;
  localparam int SH   = CROSS_FRAC_BITS - COORD_FRAC_BITS;
  localparam int NUMW = SUMW + SH;
  localparam int CXW  = COORD_W + SH + 1;
  localparam int SW   = ((CXW - 6) > 14) ? CXW - 6 : 14;
  localparam int KW   = $clog2(MAX_SPANS + 1);

  localparam logic signed [CXW-1:0] SENTINEL = {1'b0, {(CXW-1){1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_CHK, S_MA, S_MB, S_SUM, S_DIV, S_SORT, S_PAIR, S_OUT
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [CW-1:0]     vertex_total;
  logic [AW-1:0]     edge_idx;
  logic [ROW_W-1:0]  row;
  logic [FLAT_W-1:0] row_base;

  logic signed [COORD_W-1:0] x1, y1, x2, y2;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic signed [CXW-1:0]     xbuf [MAX_VERTICES];
  logic [CW-1:0]             cross_cnt;
  logic [CW-1:0]             remain;
  logic [AW-1:0]             step_cnt;
  logic [AW-1:0]             pass_cnt;
  logic signed [PW-1:0]      prod;
  logic signed [PW-1:0]      acc;
  logic                      num_neg;

  logic              pend_valid;
  logic [COL_W-1:0]  pend_start;
  logic [COL_W-1:0]  pend_end;
  logic [FLAT_W-1:0] pend_idx;
  logic [KW-1:0]     span_cnt;
  logic              ret_idle;

  logic              o_valid;
  logic              o_span_valid;
  logic [COL_W-1:0]  o_start;
  logic [COL_W-1:0]  o_end;
  logic [FLAT_W-1:0] o_idx;
  logic              o_last;

  // ---------------- request decode and vertex store ----------------
  logic          req_fire;
  logic          wr_en;
  logic [AW-1:0] nx;
  logic [AW-1:0] rd_addr;
  logic          is_last_edge;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign wr_en     = req_fire && (req.opcode == OP_APPEND) &&
                     (vertex_total < CW'(MAX_VERTICES));

  assign is_last_edge = (CW'(edge_idx) + 1'b1) >= vertex_total;
  assign nx           = is_last_edge ? '0 : edge_idx + 1'b1;
  assign rd_addr      = (state == S_RDB) ? nx : edge_idx;

  psf_vstore #(.DEPTH(MAX_VERTICES), .AW(AW)) u_vstore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (vertex_total[AW-1:0]),
    .wr_x    (req.vertex_x),
    .wr_y    (req.vertex_y),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  // ---------------- edge arithmetic ----------------
  logic [YQW-1:0]        yq_u;
  logic signed [DYW-1:0] yq_s;
  logic signed [DYW-1:0] y1e, y2e;
  logic                  hit;
  logic signed [DXW-1:0] den;
  logic signed [DXW-1:0] dx;
  logic signed [DYW-1:0] mul_a;
  logic signed [DXW-1:0] mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [SUMW-1:0] sum_raw;
  logic signed [SUMW-1:0] sum_adj;
  logic                  sum_neg;
  logic [SUMW-1:0]       sum_mag;
  logic signed [DXW-1:0] den_abs;
  logic                  div_start;
  logic                  div_done;
  logic [NUMW-1:0]       div_quo;
  logic                  div_rem_nz;
  logic signed [NUMW:0]  q_signed;
  logic signed [CXW-1:0] crossing;

  assign yq_u = YQW'(row) << COORD_FRAC_BITS;
  assign yq_s = $signed(DYW'(yq_u));
  assign y1e  = DYW'(y1);
  assign y2e  = DYW'(rd_y);
  // half-open rule: one end strictly above the row, the other on or below
  assign hit  = ((y1e < yq_s) && (y2e >= yq_s)) || ((y2e < yq_s) && (y1e >= yq_s));

  assign den   = DXW'(y2) - DXW'(y1);
  assign dx    = DXW'(x2) - DXW'(x1);
  assign mul_a = (state == S_MA) ? DYW'(x1) : (yq_s - y1e);
  assign mul_b = (state == S_MA) ? den : dx;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  assign sum_raw = SUMW'(acc) + SUMW'(prod);
  assign sum_adj = (den < 0) ? -sum_raw : sum_raw;
  assign sum_neg = sum_adj < 0;
  assign sum_mag = sum_neg ? $unsigned(-sum_adj) : $unsigned(sum_adj);
  assign den_abs = (den < 0) ? -den : den;

  assign div_start = (state == S_SUM);

  psf_div #(.NW(NUMW), .DW(DXW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (NUMW'(sum_mag) << SH),
    .den    ($unsigned(den_abs)),
    .done   (div_done),
    .quo    (div_quo),
    .rem_nz (div_rem_nz)
  );

  // floor of a negative quotient steps one further down on a remainder
  assign q_signed = num_neg ? -($signed({1'b0, div_quo}) + $signed({{NUMW{1'b0}}, div_rem_nz}))
                            : $signed({1'b0, div_quo});
  assign crossing = CXW'(q_signed);

  // ---------------- sort and pairing ----------------
  logic signed [CXW-1:0] sort_lo, sort_hi;
  logic signed [CXW:0]   c0_up;
  logic signed [CXW:0]   c0_sh;
  logic signed [SW-1:0]  s_val, e_val, s_cl, e_cl, e_max;
  logic [CFG_W-1:0]      wclip;
  logic                  span_ok;
  logic                  pair_done;

  assign sort_lo = (xbuf[0] > xbuf[1]) ? xbuf[1] : xbuf[0];
  assign sort_hi = (xbuf[0] > xbuf[1]) ? xbuf[0] : xbuf[1];

  assign c0_up = $signed((CXW+1)'(xbuf[0])) + $signed((CXW+1)'((1 << CROSS_FRAC_BITS) - 1));
  assign c0_sh = c0_up >>> CROSS_FRAC_BITS;
  assign s_val = SW'(c0_sh);
  assign e_val = SW'(xbuf[1] >>> CROSS_FRAC_BITS);
  assign wclip = (image_width > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : image_width;
  assign e_max = $signed(SW'(wclip)) - $signed(SW'(1));
  assign s_cl  = (s_val < 0) ? '0 : s_val;
  assign e_cl  = (e_val > e_max) ? e_max : e_val;
  assign span_ok   = s_cl <= e_cl;
  assign pair_done = (remain < CW'(2)) || (span_cnt == KW'(MAX_SPANS));

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      vertex_total <= '0;
      o_valid      <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_IMAGE_WIDTH:  image_width  <= cfg.data;
          REG_IMAGE_HEIGHT: image_height <= cfg.data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.opcode == OP_CLEAR) begin
              vertex_total <= '0;
            end else if (wr_en) begin
              vertex_total <= vertex_total + 1'b1;
            end else if (req.opcode == OP_QUERY) begin
              row      <= req.query_row;
              row_base <= FLAT_W'(req.query_row * image_width);
              if (CFG_W'(req.query_row) >= image_height ||
                  vertex_total < CW'(MIN_POLY_VERTICES)) begin
                o_valid      <= 1'b1;
                o_span_valid <= 1'b0;
                o_start      <= '0;
                o_end        <= '0;
                o_idx        <= '0;
                o_last       <= 1'b1;
                ret_idle     <= 1'b1;
                state        <= S_OUT;
              end else begin
                for (int j = 0; j < MAX_VERTICES; j++) xbuf[j] <= SENTINEL;
                cross_cnt  <= '0;
                edge_idx   <= '0;
                span_cnt   <= '0;
                pend_valid <= 1'b0;
                state      <= S_RDA;
              end
            end
          end
        end

        S_RDA: state <= S_RDB;

        S_RDB: begin
          x1    <= rd_x;
          y1    <= rd_y;
          state <= S_CHK;
        end

        S_CHK: begin
          x2 <= rd_x;
          y2 <= rd_y;
          if (hit && (rd_y != y1)) begin
            state <= S_MA;
          end else if (is_last_edge) begin
            step_cnt <= '0;
            pass_cnt <= '0;
            state    <= S_SORT;
          end else begin
            edge_idx <= edge_idx + 1'b1;
            state    <= S_RDA;
          end
        end

        S_MA: begin
          prod  <= mul_p;
          state <= S_MB;
        end

        S_MB: begin
          acc   <= prod;
          prod  <= mul_p;
          state <= S_SUM;
        end

        S_SUM: begin
          num_neg <= sum_neg;
          state   <= S_DIV;
        end

        S_DIV: begin
          if (div_done) begin
            // push at the tail of the crossing line
            for (int j = 0; j < MAX_VERTICES - 1; j++) xbuf[j] <= xbuf[j+1];
            xbuf[MAX_VERTICES-1] <= crossing;
            cross_cnt <= cross_cnt + 1'b1;
            if (is_last_edge) begin
              step_cnt <= '0;
              pass_cnt <= '0;
              state    <= S_SORT;
            end else begin
              edge_idx <= edge_idx + 1'b1;
              state    <= S_RDA;
            end
          end
        end

        S_SORT: begin
          if (step_cnt == AW'(MAX_VERTICES - 1)) begin
            // close the pass: move the carried maximum to the tail
            for (int j = 0; j < MAX_VERTICES - 1; j++) xbuf[j] <= xbuf[j+1];
            xbuf[MAX_VERTICES-1] <= xbuf[0];
            step_cnt <= '0;
            pass_cnt <= pass_cnt + 1'b1;
            if (pass_cnt == AW'(MAX_VERTICES - 1)) begin
              remain <= cross_cnt;
              state  <= S_PAIR;
            end
          end else begin
            // carry the larger at the head, drop the smaller at the tail
            xbuf[0] <= sort_hi;
            for (int j = 1; j < MAX_VERTICES - 1; j++) xbuf[j] <= xbuf[j+1];
            xbuf[MAX_VERTICES-1] <= sort_lo;
            step_cnt <= step_cnt + 1'b1;
          end
        end

        S_PAIR: begin
          if (pair_done) begin
            o_valid  <= 1'b1;
            o_last   <= 1'b1;
            ret_idle <= 1'b1;
            state    <= S_OUT;
            if (pend_valid) begin
              o_span_valid <= 1'b1;
              o_start      <= pend_start;
              o_end        <= pend_end;
              o_idx        <= pend_idx;
            end else begin
              o_span_valid <= 1'b0;
              o_start      <= '0;
              o_end        <= '0;
              o_idx        <= '0;
            end
          end else begin
            for (int j = 0; j < MAX_VERTICES - 2; j++) xbuf[j] <= xbuf[j+2];
            xbuf[MAX_VERTICES-2] <= SENTINEL;
            xbuf[MAX_VERTICES-1] <= SENTINEL;
            remain <= remain - CW'(2);
            if (span_ok) begin
              span_cnt   <= span_cnt + 1'b1;
              pend_valid <= 1'b1;
              pend_start <= COL_W'(s_cl);
              pend_end   <= COL_W'(e_cl);
              pend_idx   <= row_base + FLAT_W'(COL_W'(s_cl));
              // a newer span exists, so the held one is not the last
              if (pend_valid) begin
                o_valid      <= 1'b1;
                o_span_valid <= 1'b1;
                o_start      <= pend_start;
                o_end        <= pend_end;
                o_idx        <= pend_idx;
                o_last       <= 1'b0;
                ret_idle     <= 1'b0;
                state        <= S_OUT;
              end
            end
          end
        end

        S_OUT: begin
          if (rsp.ready) begin
            o_valid <= 1'b0;
            state   <= ret_idle ? S_IDLE : S_PAIR;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.span_valid  = o_span_valid;
  assign rsp.span_start  = o_start;
  assign rsp.span_end    = o_end;
  assign rsp.start_index = o_idx;
  assign rsp.last_span   = o_last;

  // ---------------- assertions ----------------
  a_no_req_while_result: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid)
    else $error("request accepted while a result is pending");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.span_valid) |-> rsp.last_span)
    else $error("no-span result not marked last");

  a_span_order: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.span_valid) |-> (rsp.span_start <= rsp.span_end))
    else $error("span start beyond span end");

  a_vertex_cap: assert property (@(posedge clk) disable iff (rst)
    vertex_total <= CW'(MAX_VERTICES))
    else $error("vertex count above capacity");

  a_span_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAIR) |-> (span_cnt <= KW'(MAX_SPANS)))
    else $error("span count above limit");

endmodule

`default_nettype wire
